[rtl/stip_pkg.sv]
// Shared types, constants and helpers for the steam table interpolator.
// Used by every module under rtl except stip_ram; depends on nothing else.
package stip_pkg;

	localparam int DATA_W = 48;
	localparam int NCOL   = 7;
	localparam int ROW_W  = NCOL * DATA_W;
	localparam int IN_W   = 400;
	localparam int MAG_W  = DATA_W + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int QUO_W  = DATA_W;
	localparam int WIDE_W = DATA_W + 2;

	// s_tdata field offsets
	localparam int OFF_ROW  = 0;
	localparam int OFF_TEMP = 7;
	localparam int OFF_COLS = 55;
	localparam int OFF_SEL  = 391;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] ST_IN    = 2'd0;
	localparam logic [1:0] ST_BELOW = 2'd1;
	localparam logic [1:0] ST_ABOVE = 2'd2;

	localparam logic [2:0] COL_P  = 3'd0;
	localparam logic [2:0] COL_LV = 3'd1;
	localparam logic [2:0] COL_VV = 3'd2;
	localparam logic [2:0] COL_LH = 3'd3;
	localparam logic [2:0] COL_VH = 3'd4;
	localparam logic [2:0] COL_LS = 3'd5;
	localparam logic [2:0] COL_VS = 3'd6;

	localparam logic [3:0] SEL_FIRST  = 4'd0;
	localparam logic [3:0] SEL_LAST_D = 4'd6;
	localparam logic [3:0] SEL_EVAP_H = 4'd7;
	localparam logic [3:0] SEL_EVAP_S = 4'd8;
	localparam logic [3:0] SEL_U_VAP  = 4'd9;
	localparam logic [3:0] SEL_U_LIQ  = 4'd10;
	localparam logic [3:0] SEL_U_EVAP = 4'd11;

	localparam wide_t SAT_MAX = 50'sd140737488355327;
	localparam wide_t SAT_MIN = -50'sd140737488355328;

	// columns that a selector needs
	function automatic logic [NCOL-1:0] col_mask(input logic [3:0] sel);
		logic [NCOL-1:0] m;
		m = '0;
		unique case (sel) inside
			[SEL_FIRST:SEL_LAST_D]: m = NCOL'(1) << sel[2:0];
			SEL_EVAP_H: m = 7'b0011000;
			SEL_EVAP_S: m = 7'b1100000;
			SEL_U_VAP:  m = 7'b0010101;
			SEL_U_LIQ:  m = 7'b0001011;
			SEL_U_EVAP: m = 7'b0011111;
			default:    m = '0;
		endcase
		return m;
	endfunction

	function automatic data_t sat48(input wide_t v);
		data_t r;
		if (v > SAT_MAX) r = SAT_MAX[DATA_W-1:0];
		else if (v < SAT_MIN) r = SAT_MIN[DATA_W-1:0];
		else r = v[DATA_W-1:0];
		return r;
	endfunction

	function automatic wide_t widen(input data_t v);
		return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	function automatic mag_t mag(input data_t v);
		logic signed [MAG_W-1:0] e;
		e = {v[DATA_W-1], v};
		return e[MAG_W-1] ? mag_t'(-e) : mag_t'(e);
	endfunction

endpackage

[rtl/steam_table_interpolator.sv]
// Top level of the steam table interpolator: sequencer, table RAMs and result register.
// Depends on stip_pkg, stip_ram, stip_mul and stip_div.
//
// Load transactions (s_tuser = 0) write one table row at the accepting edge and offer a
// zero result. Query transactions (s_tuser = 1) are taken one at a time. The block
// checks row 0 and then the last row, then scans the temperature RAM row by row.
// Below range goes straight to the result, as does a selector above 11. An exact row
// hit then reads the row, walks the columns and finishes by registering the result.
// A segment hit reads both rows of the segment and does the same walk, with a multiply
// on the shared multiplier and a divide for each column that the selector needs, up
// to five columns for the evaporation energy. Each energy product adds a further
// multiply. Results sit in an output register so the next transaction can be taken
// while one waits. Table contents are undefined until loaded; there is no clearing
// pass.
module steam_table_interpolator #(
	parameter int MAX_ROWS      = 128,
	parameter int FRACTION_BITS = 28
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// row_index[6:0], temperature, pressure_value, liquid_volume, vapour_volume,
	// liquid_enthalpy, vapour_enthalpy, liquid_entropy, vapour_entropy,
	// property_select[394:391], zero pad
	input  logic [stip_pkg::IN_W-1:0] s_tdata,
	input  logic                      s_tuser, // operation
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata, // property_value
	output logic [1:0]                m_tuser, // range_status
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [7:0]                cfg_data // rows_in_use
);
	localparam int IW = $clog2(MAX_ROWS);
	localparam int CW = ((IW > 7) ? IW : 7) + 1;
	localparam int RW = ((IW + 1) > 8) ? (IW + 1) : 8;
	localparam int DW = stip_pkg::DATA_W;

	localparam logic [4:0] S_IDLE = 5'd0,  S_RD0 = 5'd1,  S_C0  = 5'd2,  S_RDL = 5'd3,
	                       S_CL   = 5'd4,  S_RDI = 5'd5,  S_CI  = 5'd6,  S_FR  = 5'd7,
	                       S_FRW  = 5'd8,  S_FS0 = 5'd9,  S_FS1 = 5'd10, S_FS2 = 5'd11,
	                       S_COL  = 5'd12, S_MUL = 5'd13, S_DIV = 5'd14, S_EV  = 5'd15,
	                       S_EVM  = 5'd16, S_EL  = 5'd17, S_ELM = 5'd18, S_FIN = 5'd19,
	                       S_OUT  = 5'd20;

	logic [4:0]          state_q;
	logic [7:0]          rows_q;
	logic [IW-1:0]       last_q, idx_q, row_q;
	logic [2:0]          col_q;
	logic                exact_q;
	logic [3:0]          sel_q;
	stip_pkg::data_t     t_q, prev_q;
	stip_pkg::mag_t      dt_q, c_q;
	stip_pkg::data_t     vals_q [stip_pkg::NCOL];
	stip_pkg::data_t     ev_q, el_q, res_q;
	logic [1:0]          status_q;
	logic [stip_pkg::ROW_W-1:0] row0_q, row1_q;

	// load/query decode
	logic                in_acc;
	logic [CW-1:0]       wrow_ext;
	logic                wr_ok;
	logic [RW-1:0]       rows_ext, n_rows;
	stip_pkg::data_t     in_t;

	// RAMs
	logic [IW-1:0]       t_raddr, p_raddr;
	logic [DW-1:0]       t_rdata;
	logic [stip_pkg::ROW_W-1:0] p_rdata;
	stip_pkg::data_t     tr;

	// arithmetic
	logic                mul_start, mul_done, div_start, div_done;
	stip_pkg::mag_t      mul_a, mul_b;
	stip_pkg::prod_t     mul_prod;
	logic [stip_pkg::QUO_W-1:0] quo;
	logic [stip_pkg::NCOL-1:0]  need;
	stip_pkg::data_t     y0, y1, yq;
	logic signed [DW:0]  dy;
	logic                need_v, need_l;
	stip_pkg::prod_t     shp;
	logic [DW:0]         qm;
	stip_pkg::wide_t     qms;
	stip_pkg::data_t     hsel, egy;
	logic                neg_q;
	stip_pkg::data_t     fin;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign in_t      = s_tdata[stip_pkg::OFF_TEMP +: DW];
	assign wrow_ext  = CW'(s_tdata[stip_pkg::OFF_ROW +: 7]);
	assign wr_ok     = (s_tuser == stip_pkg::OP_LOAD) && in_acc && (wrow_ext < CW'(MAX_ROWS));

	// rows_in_use clamped to [2, MAX_ROWS]
	always_comb begin
		rows_ext = RW'(rows_q);
		if (rows_ext < RW'(2)) n_rows = RW'(2);
		else if (rows_ext > RW'(MAX_ROWS)) n_rows = RW'(MAX_ROWS);
		else n_rows = rows_ext;
	end

	always_comb begin
		unique case (state_q)
			S_RD0:   t_raddr = '0;
			S_RDL:   t_raddr = last_q;
			default: t_raddr = idx_q;
		endcase
		unique case (state_q)
			S_FS0:   p_raddr = row_q - IW'(1);
			default: p_raddr = row_q;
		endcase
	end

	stip_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_tram (
		.clk(clk), .we(wr_ok), .waddr(wrow_ext[IW-1:0]), .wdata(in_t),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	stip_ram #(.WIDTH(stip_pkg::ROW_W), .DEPTH(MAX_ROWS)) u_pram (
		.clk(clk), .we(wr_ok), .waddr(wrow_ext[IW-1:0]),
		.wdata(s_tdata[stip_pkg::OFF_COLS +: stip_pkg::ROW_W]),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	assign tr = t_rdata;

	// per-column segment terms
	always_comb begin
		need = stip_pkg::col_mask(sel_q);
		y0   = row0_q[col_q*DW +: DW];
		y1   = row1_q[col_q*DW +: DW];
		dy   = {y1[DW-1], y1} - {y0[DW-1], y0};
		yq   = dy[DW] ? (y0 - DW'(quo)) : (y0 + DW'(quo));
		need_v = (sel_q == stip_pkg::SEL_U_VAP) || (sel_q == stip_pkg::SEL_U_EVAP);
		need_l = (sel_q == stip_pkg::SEL_U_LIQ) || (sel_q == stip_pkg::SEL_U_EVAP);
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = dt_q;
		mul_b     = dy[DW] ? stip_pkg::mag_t'(-dy) : stip_pkg::mag_t'(dy);
		unique case (state_q)
			S_COL: mul_start = (col_q != 3'd7) && need[col_q] && !exact_q;
			S_EV: begin
				mul_start = need_v;
				mul_a = stip_pkg::mag(vals_q[stip_pkg::COL_VV]);
				mul_b = stip_pkg::mag(vals_q[stip_pkg::COL_P]);
			end
			S_EL: begin
				mul_start = need_l;
				mul_a = stip_pkg::mag(vals_q[stip_pkg::COL_LV]);
				mul_b = stip_pkg::mag(vals_q[stip_pkg::COL_P]);
			end
			default: mul_start = 1'b0;
		endcase
		div_start = (state_q == S_MUL) && mul_done;
	end

	stip_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	stip_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mul_prod),
		.divisor(c_q), .done(div_done), .quotient(quo)
	);

	// energy = h - v*p, product truncated and clamped to magnitude 2^48
	always_comb begin
		shp  = mul_prod >> FRACTION_BITS;
		qm   = ((|shp[stip_pkg::PROD_W-1:DW+1]) || (shp[DW] && (|shp[DW-1:0])))
		       ? {1'b1, {DW{1'b0}}} : shp[DW:0];
		qms  = neg_q ? -stip_pkg::wide_t'(qm) : stip_pkg::wide_t'(qm);
		hsel = (state_q == S_EVM) ? vals_q[stip_pkg::COL_VH] : vals_q[stip_pkg::COL_LH];
		egy  = stip_pkg::sat48(stip_pkg::widen(hsel) - qms);
	end

	always_comb begin
		case (sel_q) inside
			[stip_pkg::SEL_FIRST:stip_pkg::SEL_LAST_D]: fin = vals_q[sel_q[2:0]];
			stip_pkg::SEL_EVAP_H: fin = stip_pkg::sat48(
				stip_pkg::widen(vals_q[stip_pkg::COL_VH]) -
				stip_pkg::widen(vals_q[stip_pkg::COL_LH]));
			stip_pkg::SEL_EVAP_S: fin = stip_pkg::sat48(
				stip_pkg::widen(vals_q[stip_pkg::COL_VS]) -
				stip_pkg::widen(vals_q[stip_pkg::COL_LS]));
			stip_pkg::SEL_U_VAP: fin = ev_q;
			stip_pkg::SEL_U_LIQ: fin = el_q;
			stip_pkg::SEL_U_EVAP: fin = stip_pkg::sat48(
				stip_pkg::widen(ev_q) - stip_pkg::widen(el_q));
			default: fin = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rows_q   <= 8'd71;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) rows_q <= cfg_data;
			// S_OUT reloads the output register itself
			if (m_tvalid && m_tready && state_q != S_OUT) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					if (s_tuser == stip_pkg::OP_LOAD || s_tdata[stip_pkg::OFF_SEL +: 4] >
					    stip_pkg::SEL_U_EVAP) state_q <= S_OUT;
					else state_q <= S_RD0;
				end
				S_RD0: state_q <= S_C0;
				S_C0: begin
					if (t_q < tr) state_q <= S_OUT;
					else if (t_q == tr) state_q <= S_FR;
					else state_q <= S_RDL;
				end
				S_RDL: state_q <= S_CL;
				S_CL: begin
					if (t_q >= tr) state_q <= S_FR;
					else state_q <= S_RDI;
				end
				S_RDI: state_q <= S_CI;
				S_CI: begin
					if (t_q == tr) state_q <= S_FR;
					else if (t_q < tr) state_q <= S_FS0;
					else if (idx_q == last_q) state_q <= S_OUT;
					else state_q <= S_RDI;
				end
				S_FR:  state_q <= S_FRW;
				S_FRW: state_q <= S_COL;
				S_FS0: state_q <= S_FS1;
				S_FS1: state_q <= S_FS2;
				S_FS2: state_q <= S_COL;
				S_COL: begin
					if (col_q == 3'd7) state_q <= S_EV;
					else if (mul_start) state_q <= S_MUL;
				end
				S_MUL: if (mul_done) state_q <= S_DIV;
				S_DIV: if (div_done) state_q <= S_COL;
				S_EV:  state_q <= need_v ? S_EVM : S_EL;
				S_EVM: if (mul_done) state_q <= S_EL;
				S_EL:  state_q <= need_l ? S_ELM : S_FIN;
				S_ELM: if (mul_done) state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: if (!m_tvalid || m_tready) begin
					m_tvalid <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (in_acc) begin
				t_q      <= in_t;
				sel_q    <= s_tdata[stip_pkg::OFF_SEL +: 4];
				last_q   <= IW'(n_rows - RW'(1));
				res_q    <= '0;
				status_q <= stip_pkg::ST_IN;
				col_q    <= '0;
				idx_q    <= IW'(1);
			end
			S_C0: begin
				prev_q <= tr;
				row_q  <= '0;
				exact_q <= 1'b1;
				if (t_q < tr) status_q <= stip_pkg::ST_BELOW;
			end
			S_CL: begin
				row_q <= last_q;
				if (t_q > tr) status_q <= stip_pkg::ST_ABOVE;
			end
			S_CI: begin
				row_q  <= idx_q;
				prev_q <= tr;
				idx_q  <= idx_q + IW'(1);
				exact_q <= (t_q == tr);
				dt_q   <= stip_pkg::mag_t'({t_q[DW-1], t_q} - {prev_q[DW-1], prev_q});
				c_q    <= stip_pkg::mag_t'({tr[DW-1], tr} - {prev_q[DW-1], prev_q});
			end
			S_FRW: row1_q <= p_rdata;
			S_FS1: row0_q <= p_rdata;
			S_FS2: row1_q <= p_rdata;
			S_COL: if (col_q != 3'd7) begin
				if (need[col_q] && exact_q) vals_q[col_q] <= y1;
				if (!need[col_q] || exact_q) col_q <= col_q + 3'd1;
			end
			S_DIV: if (div_done) begin
				vals_q[col_q] <= yq;
				col_q <= col_q + 3'd1;
			end
			S_EV: neg_q <= vals_q[stip_pkg::COL_VV][DW-1] ^ vals_q[stip_pkg::COL_P][DW-1];
			S_EVM: if (mul_done) ev_q <= egy;
			S_EL: neg_q <= vals_q[stip_pkg::COL_LV][DW-1] ^ vals_q[stip_pkg::COL_P][DW-1];
			S_ELM: if (mul_done) el_q <= egy;
			S_FIN: res_q <= fin;
			S_OUT: if (!m_tvalid || m_tready) begin
				m_tdata <= res_q;
				m_tuser <= status_q;
			end
			default: ;
		endcase
	end

	// checks
	a_mul_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL || state_q == S_EVM || state_q == S_ELM))
		else $error("multiplier finished outside a waiting state");
	a_div_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its waiting state");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction taken while one is in flight");
	a_below_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == stip_pkg::ST_BELOW) |-> (m_tdata == '0))
		else $error("below-range result is not zero");
endmodule

[rtl/stip_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stip_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/stip_mul.sv]
// Multi-cycle unsigned 49x49 multiplier: four 25x25 partial products.
// Depends on stip_pkg.
module stip_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  stip_pkg::mag_t a,
	input  stip_pkg::mag_t b,
	output logic           done,
	output stip_pkg::prod_t prod
);
	localparam int HW = 25;

	stip_pkg::mag_t   a_q, b_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic [2*HW-1:0]  pp_s1;
	logic [6:0]       sh_s1;
	logic [HW-1:0]    pa, pb;
	logic [6:0]       sh;

	always_comb begin
		pa = cnt_q[1] ? HW'(a_q[stip_pkg::MAG_W-1:HW]) : a_q[HW-1:0];
		pb = cnt_q[0] ? HW'(b_q[stip_pkg::MAG_W-1:HW]) : b_q[HW-1:0];
		sh = 7'((32'(cnt_q[1]) + 32'(cnt_q[0])) * HW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			prod <= '0;
		end else if (busy_q) begin
			pp_s1 <= pa * pb;
			sh_s1 <= sh;
			if (cnt_q != 3'd0) prod <= prod + (stip_pkg::prod_t'(pp_s1) << sh_s1);
		end
	end
endmodule

[rtl/stip_div.sv]
// Restoring divider, one quotient bit per cycle; quotient must fit 48 bits.
// Depends on stip_pkg.
module stip_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  stip_pkg::prod_t dividend,
	input  stip_pkg::mag_t  divisor,
	output logic            done,
	output logic [stip_pkg::QUO_W-1:0] quotient
);
	localparam int MW = stip_pkg::MAG_W;
	localparam int QW = stip_pkg::QUO_W;

	logic [MW-1:0] r_q, d_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [MW:0]   tr;
	logic          ge;

	always_comb begin
		tr = {r_q, quotient[QW-1]};
		ge = tr >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(QW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q      <= dividend[QW+MW-1:QW];
			quotient <= dividend[QW-1:0];
			d_q      <= divisor;
		end else if (busy_q) begin
			r_q      <= ge ? MW'(tr - {1'b0, d_q}) : tr[MW-1:0];
			quotient <= {quotient[QW-2:0], ge};
		end
	end
endmodule

[tb/sv/tb.sv]
// Self-checking bench for steam_table_interpolator: loads a steam table, then runs queries.
// Every result is checked against the bench's own interpolation of the table it has loaded.
// Depends on stip_pkg and the RTL under rtl.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC      = 28;
	localparam int ROWS      = 128;
	localparam int CYC_LIMIT = 4_000_000;
	localparam longint DMAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint DMIN  = -64'sh0000_8000_0000_0000;

	typedef enum int {LOC_ROW, LOC_SEG, LOC_BELOW, LOC_NONE} loc_t;

	typedef struct {
		logic            op;
		logic [6:0]      row;
		stip_pkg::data_t temp;
		stip_pkg::data_t cols [stip_pkg::NCOL];
		logic [3:0]      sel;
	} steam_item_t;

	typedef struct {
		stip_pkg::data_t value;
		logic [1:0]      status;
	} steam_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [stip_pkg::IN_W-1:0] s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [47:0]      m_tdata;
	logic [1:0]       m_tuser;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [7:0]       cfg_data = '0;

	// pending stimulus and the results it is predicted to give
	steam_item_t   pending_items [$];
	steam_result_t expected_props [$];
	steam_item_t   cur_item;

	// predictor's copy of the table and the row count register
	longint   temp_col [ROWS];
	longint   prop_col [stip_pkg::NCOL][ROWS];
	int       pred_rows = 71;

	// generator's view of row temperatures, used to aim queries
	longint   sent_temps [ROWS];
	longint   base_temps [ROWS];

	int       cyc = 0;
	int       fail_cnt = 0;
	int       n_loads = 0, n_queries = 0, n_below = 0, n_above = 0, n_checked = 0;
	int       hold_left = 0;
	bit       held_once = 0;

	steam_table_interpolator #(.MAX_ROWS(ROWS), .FRACTION_BITS(FRAC)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic logic [63:0] magn(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp48(input longint v);
		if (v > DMAX) return DMAX;
		if (v < DMIN) return DMIN;
		return v;
	endfunction

	// Q product; magnitude truncated and capped at 2^48
	function automatic longint q_product(input longint a, input longint b);
		logic [127:0] p;
		longint m;
		p = {64'd0, magn(a)} * {64'd0, magn(b)};
		p = p >> FRAC;
		if (p > (128'd1 << 48)) p = 128'd1 << 48;
		m = longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	// one column at the located row, or interpolated across the located segment
	function automatic longint column_at(input int c, input loc_t loc, input int r,
			input longint t);
		longint y0, y1, dy, dt, span;
		logic [127:0] num, quo;
		if (loc == LOC_ROW) return prop_col[c][r];
		if (loc != LOC_SEG) return 0;
		y0   = prop_col[c][r-1];
		y1   = prop_col[c][r];
		dy   = y1 - y0;
		dt   = t - temp_col[r-1];
		span = temp_col[r] - temp_col[r-1];
		num  = {64'd0, 64'(dt)} * {64'd0, magn(dy)};
		quo  = num / {64'd0, 64'(span)};
		return dy < 0 ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
	endfunction

	// internal energy h - v*p
	function automatic longint energy_at(input int hc, input int vc, input loc_t loc,
			input int r, input longint t);
		return clamp48(column_at(hc, loc, r, t)
			- q_product(column_at(vc, loc, r, t), column_at(stip_pkg::COL_P, loc, r, t)));
	endfunction

	// applies one accepted transaction to the table and queues its result
	function automatic void predict_property(input steam_item_t it);
		steam_result_t res;
		longint t, v;
		loc_t loc;
		int r, n;
		t = longint'(it.temp);
		res.value = '0;
		res.status = stip_pkg::ST_IN;
		if (it.op == stip_pkg::OP_LOAD) begin
			temp_col[it.row] = t;
			for (int c = 0; c < stip_pkg::NCOL; c++)
				prop_col[c][it.row] = longint'(it.cols[c]);
			n_loads++;
			expected_props.push_back(res);
			return;
		end
		n_queries++;
		n = pred_rows < 2 ? 2 : (pred_rows > ROWS ? ROWS : pred_rows);
		loc = LOC_NONE;
		r = 0;
		v = 0;
		if (it.sel <= stip_pkg::SEL_U_EVAP) begin
			if (t < temp_col[0]) begin
				loc = LOC_BELOW;
				res.status = stip_pkg::ST_BELOW;
			end else if (t == temp_col[0]) begin
				loc = LOC_ROW;
			end else if (t == temp_col[n-1]) begin
				loc = LOC_ROW;
				r = n - 1;
			end else if (t > temp_col[n-1]) begin
				loc = LOC_ROW;
				r = n - 1;
				res.status = stip_pkg::ST_ABOVE;
			end else begin
				for (int i = 1; i < n; i++) begin
					if (t == temp_col[i]) begin
						loc = LOC_ROW;
						r = i;
						break;
					end
					if (t < temp_col[i]) begin
						loc = LOC_SEG;
						r = i;
						break;
					end
				end
			end
			case (it.sel)
				stip_pkg::SEL_EVAP_H: v = clamp48(column_at(stip_pkg::COL_VH, loc, r, t)
					- column_at(stip_pkg::COL_LH, loc, r, t));
				stip_pkg::SEL_EVAP_S: v = clamp48(column_at(stip_pkg::COL_VS, loc, r, t)
					- column_at(stip_pkg::COL_LS, loc, r, t));
				stip_pkg::SEL_U_VAP:  v = energy_at(stip_pkg::COL_VH, stip_pkg::COL_VV,
					loc, r, t);
				stip_pkg::SEL_U_LIQ:  v = energy_at(stip_pkg::COL_LH, stip_pkg::COL_LV,
					loc, r, t);
				stip_pkg::SEL_U_EVAP: v = clamp48(
					energy_at(stip_pkg::COL_VH, stip_pkg::COL_VV, loc, r, t)
					- energy_at(stip_pkg::COL_LH, stip_pkg::COL_LV, loc, r, t));
				default:    v = column_at(int'(it.sel), loc, r, t);
			endcase
			if (loc == LOC_BELOW || loc == LOC_NONE) v = 0;
		end
		if (res.status == stip_pkg::ST_BELOW) n_below++;
		if (res.status == stip_pkg::ST_ABOVE) n_above++;
		res.value = stip_pkg::data_t'(v);
		expected_props.push_back(res);
	endfunction

	// ---------------------------------------------------------------- driver

	function automatic logic [stip_pkg::IN_W-1:0] pack_item(input steam_item_t it);
		logic [stip_pkg::IN_W-1:0] d;
		d = '0;
		d[stip_pkg::OFF_ROW +: 7] = it.row;
		d[stip_pkg::OFF_TEMP +: stip_pkg::DATA_W] = it.temp;
		for (int c = 0; c < stip_pkg::NCOL; c++)
			d[stip_pkg::OFF_COLS + c*stip_pkg::DATA_W +: stip_pkg::DATA_W] = it.cols[c];
		d[stip_pkg::OFF_SEL +: 4] = it.sel;
		return d;
	endfunction

	// idling off for the first quarter of each window of the cycle counter, then random idling
	function automatic bit idle_now();
		return (cyc % 40000) >= 10000 && $urandom_range(0, 99) < 8;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) predict_property(cur_item);
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && !idle_now()) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= pack_item(cur_item);
					s_tuser  <= cur_item.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// one long hold-off once the input queue holds over 40 items, so the block backs up
	always @(posedge clk) begin
		if (!held_once && arst_n && pending_items.size() > 40 && cyc > 2000) begin
			hold_left <= 3000;
			held_once <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= hold_left == 0 && !idle_now();
		end
	end

	// result monitor
	always @(posedge clk) begin
		steam_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_props.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("[%0d] unexpected result value=%h status=%0d", cyc, m_tdata, m_tuser);
			end else begin
				e = expected_props.pop_front();
				n_checked++;
				if (m_tdata !== e.value || m_tuser !== e.status) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("[%0d] mismatch: value exp %h got %h, status exp %0d got %0d",
							cyc, e.value, m_tdata, e.status, m_tuser);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYC_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic stip_pkg::data_t rand48();
		return stip_pkg::data_t'({$urandom, $urandom});
	endfunction

	// random property value, now and then an extreme
	function automatic stip_pkg::data_t rand_value();
		case ($urandom_range(0, 19))
			0: return stip_pkg::data_t'(DMAX);
			1: return stip_pkg::data_t'(DMIN);
			2: return '0;
			3: return '1;
			default: return rand48();
		endcase
	endfunction

	task automatic push_load(input int row, input longint t);
		steam_item_t it;
		it.op = stip_pkg::OP_LOAD;
		it.row = 7'(row);
		it.temp = stip_pkg::data_t'(t);
		for (int c = 0; c < stip_pkg::NCOL; c++) it.cols[c] = rand_value();
		it.sel = 4'($urandom_range(0, 15));
		sent_temps[row] = t;
		pending_items.push_back(it);
	endtask

	task automatic push_query(input longint t, input int sel);
		steam_item_t it;
		it.op = stip_pkg::OP_QUERY;
		it.row = 7'($urandom_range(0, 127));
		it.temp = stip_pkg::data_t'(t);
		for (int c = 0; c < stip_pkg::NCOL; c++) it.cols[c] = rand48();
		it.sel = 4'(sel);
		pending_items.push_back(it);
	endtask

	// query temperature inside segment i, or its lower row when it has no interior
	function automatic longint seg_temp(input int i);
		longint gap;
		logic [63:0] rv;
		gap = sent_temps[i] - sent_temps[i-1];
		if (gap <= 1) return sent_temps[i-1];
		rv = {$urandom, $urandom};
		return sent_temps[i-1] + 1 + longint'(rv % 64'(gap - 1));
	endfunction

	function automatic longint pick_query_temp(input int n);
		int m;
		m = $urandom_range(0, 99);
		if (m < 3) return DMIN;
		if (m < 6) return DMAX;
		if (m < 12) return sent_temps[0] - 1 - $urandom_range(0, 1000);
		if (m < 18) return sent_temps[n-1] + 1 + $urandom_range(0, 1000);
		if (m < 38) return sent_temps[$urandom_range(0, n-1)];
		if (m < 42) return longint'(rand48());
		return seg_temp($urandom_range(1, n-1));
	endfunction

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_items.size() > 0 || s_tvalid || expected_props.size() > 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_rows(input int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= 8'(v);
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		pred_rows = v;
	endtask

	task automatic random_phase(input int count);
		int n;
		int r;
		n = pred_rows < 2 ? 2 : (pred_rows > ROWS ? ROWS : pred_rows);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 12) begin
				r = $urandom_range(0, 127);
				// mostly keep the table sorted; now and then break it until reloaded
				push_load(r, $urandom_range(0, 24) == 0 ? longint'(rand48()) : base_temps[r]);
			end else begin
				push_query(pick_query_temp(n), $urandom_range(0, 15));
			end
		end
		wait_drained();
	endtask

	initial begin
		int phase_rows [7];
		longint t;
		phase_rows = '{2, 128, 0, 255, 1, 71, 0};
		phase_rows[6] = $urandom_range(3, 127);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// fill every row with ascending temperatures
		t = -(64'sd1 <<< 46) + longint'($urandom_range(0, 1 << 20));
		for (int r = 0; r < ROWS; r++) begin
			base_temps[r] = t;
			push_load(r, t);
			t += 1 + longint'({$urandom_range(0, 63), $urandom});
		end

		// directed: extremes of range, exact rows, every selector mid-segment
		push_query(sent_temps[0] - 1, stip_pkg::SEL_FIRST);
		push_query(DMIN, stip_pkg::SEL_U_EVAP);
		push_query(sent_temps[0], stip_pkg::SEL_U_VAP);
		push_query(sent_temps[70], stip_pkg::SEL_EVAP_H);
		push_query(sent_temps[70] + 1, stip_pkg::SEL_U_LIQ);
		push_query(DMAX, stip_pkg::SEL_LAST_D);
		push_query(sent_temps[30], 4'd13);
		for (int s = 0; s < 16; s++) push_query(seg_temp(1 + s * 4), s);
		// row at the top of the index range, reloaded with random values
		push_load(127, base_temps[127]);
		wait_drained();

		random_phase(150);
		foreach (phase_rows[i]) begin
			write_rows(phase_rows[i]);
			random_phase(i == 1 || i == 3 ? 120 : 190);
		end

		repeat (800) @(posedge clk);
		$display("tb: %0d loads, %0d queries (%0d below, %0d above range), %0d results checked",
			n_loads, n_queries, n_below, n_above, n_checked);
		$display("tb: row counts 0..255 incl. clamped values, long output hold-off applied");
		if (fail_cnt == 0 && expected_props.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d mismatches, %0d results missing", fail_cnt, expected_props.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
